### design/prrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prrs_pkg;

  localparam int unsigned LEVELS_DEF    = 8;
  localparam int unsigned SLOTS_DEF     = 16;
  localparam int unsigned TIME_BITS_DEF = 32;

  localparam int unsigned PID_W    = 8;
  localparam int unsigned LVL_IN_W = 3;
  localparam int unsigned BURST_W  = 16;
  localparam int unsigned OTIME_W  = 32;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 176;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ARRIVE = 2'd0,
    KIND_RUN    = 2'd1,
    KIND_IDLE   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_REQUEUE,
    ST_PICK,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
  } lvl_cmd_t;

endpackage

`default_nettype wire

### design/prrs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module prrs_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### design/prrs_level_ctl.sv
`timescale 1ns / 1ps
`default_nettype none

module prrs_level_ctl import prrs_pkg::*; #(
  parameter int unsigned LEVELS = LEVELS_DEF,
  parameter int unsigned SLOTS  = SLOTS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire lvl_cmd_t                  cmd_i,
  input  wire logic [$clog2(LEVELS)-1:0] lv_i,
  input  wire logic [$clog2(SLOTS)-1:0]  slot_i,
  input  wire logic [$clog2(SLOTS)-1:0]  next_i,
  output logic      [$clog2(SLOTS)-1:0]  head_o,
  output logic      [$clog2(SLOTS)-1:0]  tail_o,
  output logic                           sel_ne_o,
  output logic                           any_o,
  output logic      [$clog2(LEVELS)-1:0] pick_o
);

  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned SW = $clog2(SLOTS);

  logic [SW-1:0]     head_q [LEVELS];
  logic [SW-1:0]     tail_q [LEVELS];
  logic [LEVELS-1:0] ne_q;

  assign head_o   = head_q[lv_i];
  assign tail_o   = tail_q[lv_i];
  assign sel_ne_o = ne_q[lv_i];
  assign any_o    = |ne_q;

  always_comb begin
    pick_o = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (ne_q[i]) begin
        pick_o = LW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else if (cmd_i.push) begin
      if (!ne_q[lv_i]) begin
        head_q[lv_i] <= slot_i;
        ne_q[lv_i]   <= 1'b1;
      end
      tail_q[lv_i] <= slot_i;
    end else if (cmd_i.pop) begin
      if (head_q[lv_i] == tail_q[lv_i]) begin
        ne_q[lv_i] <= 1'b0;
      end else begin
        head_q[lv_i] <= next_i;
      end
    end
  end

endmodule

`default_nettype wire

### design/priority_round_robin_scheduler.sv
// An arrive beat is taken in the idle state and handled in the arrive step; a tick goes
// through the requeue and pick steps and, if it runs a task, the run step.
// One beat at a time; a tick is handled by the requeue step, the task-table read in the
// pick step and its write-back in the run step. m_axis_tvalid rises once a result is loaded.
// A waiting result holds in the output register; the next beat is taken once it is loaded.
// Reset is asynchronous, active low: all FIFOs empty, every slot free, time zero.
`timescale 1ns / 1ps
`default_nettype none

module priority_round_robin_scheduler import prrs_pkg::*; #(
  parameter int unsigned LEVELS    = LEVELS_DEF,
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // pid[7:0], level[10:8], burst[26:11], zero fill
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[0]
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // rejected[0], task_id[8:1], slice_start[40:9], finished[41], first_start[73:42],
  // finish_time[105:74], turnaround[137:106], waiting[169:138], zero fill
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  // kind[1:0]
  output logic      [OUT_USER_W-1:0] m_axis_tuser
);

  localparam int unsigned LW    = $clog2(LEVELS);
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned TB    = TIME_BITS;
  localparam int unsigned P_REM = PID_W;
  localparam int unsigned P_BST = P_REM + BURST_W;
  localparam int unsigned P_ARR = P_BST + BURST_W;
  localparam int unsigned P_FST = P_ARR + TB;
  localparam int unsigned P_STA = P_FST + TB;
  localparam int unsigned EW    = P_STA + 1;

  state_e state_q, state_d;

  logic               in_beat;
  logic               out_free;
  logic [LVL_IN_W-1:0] in_level;
  logic [LW-1:0]      lvl_sat;

  cmd_e               cmd_q;
  logic [PID_W-1:0]   pid_q;
  logic [LW-1:0]      lvl_q;
  logic [BURST_W-1:0] burst_q;

  logic [TB-1:0]      time_q, time_d;
  logic [SLOTS-1:0]   free_q, free_d;
  logic               pend_valid_q, pend_valid_d;
  logic [SW-1:0]      pend_slot_q, pend_slot_d;
  logic [LW-1:0]      pend_lv_q, pend_lv_d;
  logic [LW-1:0]      lv_q, lv_d;
  logic [SW-1:0]      slot_q, slot_d;

  logic [SW-1:0]      free_idx;
  logic               any_free;

  lvl_cmd_t           lcmd;
  logic [LW-1:0]      lv_sel;
  logic [SW-1:0]      push_slot;
  logic [SW-1:0]      q_head;
  logic [SW-1:0]      q_tail;
  logic               sel_ne;
  logic               any_ne;
  logic [LW-1:0]      pick_lv;

  logic               link_we;
  logic [SW-1:0]      link_rd;
  logic               rd_en;
  logic               ent_we;
  logic [SW-1:0]      ent_waddr;
  logic [EW-1:0]      ent_wdata;
  logic [EW-1:0]      ent_rd;

  logic [PID_W-1:0]   e_pid;
  logic [BURST_W-1:0] e_rem;
  logic [BURST_W-1:0] e_burst;
  logic [TB-1:0]      e_arr;
  logic [TB-1:0]      e_first;
  logic               e_started;
  logic [TB-1:0]      run_first;
  logic               rem_dec;
  logic [BURST_W-1:0] run_rem;
  logic [TB-1:0]      run_time;
  logic               run_fin;
  logic [TB-1:0]      run_ta;
  logic [TB-1:0]      run_wt;

  logic               load;
  logic               out_valid_q, out_valid_d;
  kind_e              kind_q, kind_d;
  logic               rej_q, rej_d;
  logic [PID_W-1:0]   task_q, task_d;
  logic [OTIME_W-1:0] slice_q, slice_d;
  logic               fin_q, fin_d;
  logic [OTIME_W-1:0] first_q, first_d;
  logic [OTIME_W-1:0] ftime_q, ftime_d;
  logic [OTIME_W-1:0] ta_q, ta_d;
  logic [OTIME_W-1:0] wt_q, wt_d;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign in_level = s_axis_tdata[PID_W +: LVL_IN_W];
  assign lvl_sat  = (32'(in_level) >= LEVELS) ? LW'(LEVELS - 1) : LW'(in_level);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {6'd0, wt_q, ta_q, ftime_q, first_q, fin_q, slice_q, task_q, rej_q};

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        free_idx = SW'(i);
      end
    end
  end
  assign any_free = |free_q;

  prrs_level_ctl #(
    .LEVELS (LEVELS),
    .SLOTS  (SLOTS)
  ) u_level_ctl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (lcmd),
    .lv_i     (lv_sel),
    .slot_i   (push_slot),
    .next_i   (link_rd),
    .head_o   (q_head),
    .tail_o   (q_tail),
    .sel_ne_o (sel_ne),
    .any_o    (any_ne),
    .pick_o   (pick_lv)
  );

  prrs_ram #(
    .W     (SW),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (q_tail),
    .wdata_i (push_slot),
    .re_i    (rd_en),
    .raddr_i (q_head),
    .rdata_o (link_rd)
  );

  prrs_ram #(
    .W     (EW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (rd_en),
    .raddr_i (q_head),
    .rdata_o (ent_rd)
  );

  assign e_pid     = ent_rd[0 +: PID_W];
  assign e_rem     = ent_rd[P_REM +: BURST_W];
  assign e_burst   = ent_rd[P_BST +: BURST_W];
  assign e_arr     = ent_rd[P_ARR +: TB];
  assign e_first   = ent_rd[P_FST +: TB];
  assign e_started = ent_rd[P_STA];

  assign run_first = e_started ? e_first : time_q;
  assign rem_dec   = (e_rem != '0);
  assign run_rem   = rem_dec ? e_rem - BURST_W'(1) : e_rem;
  assign run_time  = rem_dec ? time_q + TB'(1) : time_q;
  assign run_fin   = (run_rem == '0);
  assign run_ta    = run_time - e_arr;
  assign run_wt    = run_ta - TB'(e_burst);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d = (cmd_e'(s_axis_tuser[0]) == CMD_TICK) ? ST_REQUEUE : ST_ARRIVE;
        end
      end
      ST_ARRIVE: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_REQUEUE: state_d = ST_PICK;
      ST_PICK: begin
        if (any_ne) begin
          state_d = ST_RUN;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    lcmd         = '0;
    lv_sel       = lvl_q;
    push_slot    = free_idx;
    rd_en        = 1'b0;
    ent_we       = 1'b0;
    ent_waddr    = free_idx;
    ent_wdata    = {1'b0, {TB{1'b0}}, time_q, burst_q, burst_q, pid_q};
    load         = 1'b0;
    time_d       = time_q;
    free_d       = free_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    pend_lv_d    = pend_lv_q;
    lv_d         = lv_q;
    slot_d       = slot_q;
    kind_d       = KIND_ARRIVE;
    rej_d        = 1'b0;
    task_d       = '0;
    slice_d      = '0;
    fin_d        = 1'b0;
    first_d      = '0;
    ftime_d      = '0;
    ta_d         = '0;
    wt_d         = '0;
    case (state_q)
      ST_ARRIVE: begin
        if (out_free) begin
          load = 1'b1;
          if (!any_free) begin
            rej_d = 1'b1;
          end else begin
            ent_we           = 1'b1;
            lcmd.push        = 1'b1;
            free_d[free_idx] = 1'b0;
          end
        end
      end
      ST_REQUEUE: begin
        lv_sel    = pend_lv_q;
        push_slot = pend_slot_q;
        if (pend_valid_q) begin
          lcmd.push    = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
      ST_PICK: begin
        lv_sel = pick_lv;
        if (any_ne) begin
          rd_en  = 1'b1;
          lv_d   = pick_lv;
          slot_d = q_head;
        end else if (out_free) begin
          load    = 1'b1;
          kind_d  = KIND_IDLE;
          slice_d = OTIME_W'(time_q);
          time_d  = time_q + TB'(1);
        end
      end
      ST_RUN: begin
        lv_sel = lv_q;
        if (out_free) begin
          load      = 1'b1;
          lcmd.pop  = 1'b1;
          ent_we    = 1'b1;
          ent_waddr = slot_q;
          ent_wdata = {1'b1, run_first, e_arr, e_burst, run_rem, e_pid};
          time_d    = run_time;
          kind_d    = KIND_RUN;
          task_d    = e_pid;
          slice_d   = OTIME_W'(time_q);
          first_d   = OTIME_W'(run_first);
          if (run_fin) begin
            fin_d          = 1'b1;
            ftime_d        = OTIME_W'(run_time);
            ta_d           = OTIME_W'(run_ta);
            wt_d           = OTIME_W'(run_wt);
            free_d[slot_q] = 1'b1;
          end else begin
            pend_valid_d = 1'b1;
            pend_slot_d  = slot_q;
            pend_lv_d    = lv_q;
          end
        end
      end
      default: ;
    endcase
    link_we     = lcmd.push && sel_ne;
    out_valid_d = load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      time_q       <= '0;
      free_q       <= '1;
      pend_valid_q <= 1'b0;
      pend_slot_q  <= '0;
      pend_lv_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      time_q       <= time_d;
      free_q       <= free_d;
      pend_valid_q <= pend_valid_d;
      pend_slot_q  <= pend_slot_d;
      pend_lv_q    <= pend_lv_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lv_q   <= lv_d;
    slot_q <= slot_d;
    if (in_beat) begin
      cmd_q   <= cmd_e'(s_axis_tuser[0]);
      pid_q   <= s_axis_tdata[0 +: PID_W];
      lvl_q   <= lvl_sat;
      burst_q <= s_axis_tdata[PID_W + LVL_IN_W +: BURST_W];
    end
    if (load) begin
      kind_q  <= kind_d;
      rej_q   <= rej_d;
      task_q  <= task_d;
      slice_q <= slice_d;
      fin_q   <= fin_d;
      first_q <= first_d;
      ftime_q <= ftime_d;
      ta_q    <= ta_d;
      wt_q    <= wt_d;
    end
  end

  a_arrive_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ARRIVE) |-> (cmd_q == CMD_ARRIVE))
    else $error("arrive step entered for a tick beat");

  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> !free_q[pend_slot_q])
    else $error("preempted task sits in a free slot");

  a_pop_ne: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcmd.pop |-> sel_ne)
    else $error("pop from an empty level");

  a_time_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(load) |-> (time_q == $past(time_q)))
    else $error("time advanced without a result");

endmodule

`default_nettype wire
